/* rtl/core/bvph_pkg.sv */
// shared types, constants and functions of the bill validator poll host
package bvph_pkg;

    // event opcodes
    localparam logic [1:0] OP_RX_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISABLE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_DEVICE_ADDR   = 2'd1;
    localparam logic [1:0] CFG_ENABLE_MASK   = 2'd2;

    // configuration reset values
    localparam logic [15:0] POLL_INTERVAL_RST = 16'd200;
    localparam logic [7:0]  DEVICE_ADDR_RST   = 8'h03;
    localparam logic [47:0] ENABLE_MASK_RST   = 48'hFFFF_FFFF_FFFF;

    // link framing
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [7:0]  SYNC_BYTE  = 8'h02;
    localparam logic [7:0]  LEN_SHORT  = 8'd6;
    localparam logic [7:0]  LEN_ENABLE = 8'd12;
    localparam logic [7:0]  LEN_MIN    = 8'd6;
    localparam logic [7:0]  RX_MAX     = 8'd255;

    // command codes sent to the validator
    localparam logic [7:0] CMD_ACK    = 8'h00;
    localparam logic [7:0] CMD_RESET  = 8'h30;
    localparam logic [7:0] CMD_POLL   = 8'h33;
    localparam logic [7:0] CMD_ENABLE = 8'h34;
    localparam logic [7:0] CMD_STACK  = 8'h35;

    // device status codes
    localparam logic [7:0] ST_IDLE      = 8'h00;
    localparam logic [7:0] ST_POWER_UP  = 8'h10;
    localparam logic [7:0] ST_DISABLED  = 8'h19;
    localparam logic [7:0] ST_ESCROW    = 8'h80;
    localparam logic [7:0] ST_STACKED   = 8'h81;
    localparam logic [7:0] ST_RETURNED  = 8'h82;

    // bound on bill type codes; only codes below it are credited
    localparam int BILL_TYPES = 8;

    // kind of outgoing transaction group
    typedef enum logic [1:0] {
        JOB_REPORT,
        JOB_SHORT,
        JOB_ENABLE
    } t_job_kind;

    // one unit of work handed from the event logic to the transmitter
    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [47:0] mask;
        logic        frame_done;
        logic        frame_ok;
        logic [7:0]  status;
        logic [12:0] credit;
    } t_job;

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // money value of a bill type
    function automatic logic [12:0] bill_value(input logic [4:0] t);
        logic [12:0] v;
        case (t)
            5'd2:    v = 13'd10;
            5'd3:    v = 13'd50;
            5'd4:    v = 13'd100;
            5'd5:    v = 13'd500;
            5'd6:    v = 13'd1000;
            5'd7:    v = 13'd5000;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/bvph_in_if.sv */
// event channel into the poll host
interface bvph_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source(output valid, output opcode, output rx_byte, input ready);
    modport sink(input valid, input opcode, input rx_byte, output ready);
endinterface

/* rtl/core/bvph_out_if.sv */
// result channel out of the poll host
interface bvph_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        frame_done;
    logic        frame_ok;
    logic [7:0]  device_status;
    logic [12:0] credit;

    modport source(output valid, output tx_valid, output tx_byte, output tx_last,
                   output frame_done, output frame_ok, output device_status,
                   output credit, input ready);
    modport sink(input valid, input tx_valid, input tx_byte, input tx_last,
                 input frame_done, input frame_ok, input device_status,
                 input credit, output ready);
endinterface

/* rtl/core/bvph_event.sv */
// event logic: receive framing, crc check, poll timer and command choice
module bvph_event (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bvph_in_if.sink              i_ev,
    input  logic [15:0]          i_poll_interval,
    input  logic [7:0]           i_device_addr,
    input  logic [47:0]          i_enable_mask,
    output bvph_pkg::t_job       o_job,
    output logic                 o_job_valid,
    input  logic                 i_job_take
);
    import bvph_pkg::*;

    logic [7:0]  r_count,     n_count;
    logic [7:0]  r_frame_len, n_frame_len;
    logic [15:0] r_crc,       n_crc;
    logic [7:0]  r_status,    n_status;
    logic [7:0]  r_bill,      n_bill;
    logic [7:0]  r_pending,   n_pending;
    logic [7:0]  r_last,      n_last;
    logic [15:0] r_tick,      n_tick;
    logic        r_job_valid, n_job_valid;
    t_job        r_job,       n_job;

    logic        accept;
    logic        has_job;
    logic [7:0]  cnt_inc;
    logic [15:0] crc_inc;
    logic [15:0] tick_inc;
    logic        done;
    logic        ok;

    assign i_ev.ready  = !r_job_valid || i_job_take;
    assign accept      = i_ev.valid && i_ev.ready;
    assign o_job       = r_job;
    assign o_job_valid = r_job_valid;

    // next state for one event
    always_comb begin
        n_count     = r_count;
        n_frame_len = r_frame_len;
        n_crc       = r_crc;
        n_status    = r_status;
        n_bill      = r_bill;
        n_pending   = r_pending;
        n_last      = r_last;
        n_tick      = r_tick;
        has_job     = 1'b0;
        done        = 1'b0;
        ok          = 1'b0;
        cnt_inc     = r_count + 8'd1;
        crc_inc     = crc_step(r_crc, i_ev.rx_byte);
        tick_inc    = r_tick + 16'd1;
        n_job.kind       = JOB_REPORT;
        n_job.addr       = i_device_addr;
        n_job.cmd        = CMD_POLL;
        n_job.mask       = i_enable_mask;
        n_job.frame_done = 1'b0;
        n_job.frame_ok   = 1'b0;
        n_job.status     = r_last;
        n_job.credit     = 13'd0;

        unique case (i_ev.opcode)
            OP_RX_BYTE: begin
                // receive byte, dropped while hunting for sync
                if (r_count != 8'd0 || i_ev.rx_byte == SYNC_BYTE) begin
                    n_crc   = crc_inc;
                    n_count = cnt_inc;
                    if (r_count == 8'd2) begin
                        n_frame_len = i_ev.rx_byte;
                    end else if (r_count == 8'd3) begin
                        n_status = i_ev.rx_byte;
                    end else if (r_count == 8'd4) begin
                        n_bill = i_ev.rx_byte;
                    end
                    // end of frame checks
                    if (cnt_inc == 8'd5 && n_frame_len < LEN_MIN) begin
                        done = 1'b1;
                    end else if (cnt_inc >= LEN_MIN && cnt_inc == n_frame_len) begin
                        done = 1'b1;
                        ok   = (crc_inc == 16'd0);
                    end else if (cnt_inc == RX_MAX) begin
                        done = 1'b1;
                    end
                    if (done) begin
                        n_count          = 8'd0;
                        n_crc            = 16'd0;
                        has_job          = 1'b1;
                        n_job.frame_done = 1'b1;
                        n_job.frame_ok   = ok;
                        if (ok) begin
                            // ack only when the last reply asked for no command
                            if (r_pending == ST_IDLE) begin
                                n_job.kind = JOB_SHORT;
                                n_job.cmd  = CMD_ACK;
                            end
                            n_last = n_status;
                            if (n_status == ST_POWER_UP || n_status == ST_DISABLED ||
                                n_status == ST_ESCROW || n_status == ST_RETURNED) begin
                                n_pending = n_status;
                            end else begin
                                n_pending = ST_IDLE;
                            end
                            if (n_status == ST_STACKED && n_bill < 8'(BILL_TYPES)) begin
                                n_job.credit = bill_value(n_bill[4:0]);
                            end
                            n_job.status = n_status;
                        end
                    end
                end
            end
            OP_TICK: begin
                // poll timer
                if (tick_inc >= i_poll_interval) begin
                    n_tick  = 16'd0;
                    has_job = 1'b1;
                    if (r_pending == ST_DISABLED) begin
                        n_job.kind = JOB_ENABLE;
                        n_job.cmd  = CMD_ENABLE;
                    end else begin
                        n_job.kind = JOB_SHORT;
                        if (r_pending == ST_POWER_UP) begin
                            n_job.cmd = CMD_RESET;
                        end else if (r_pending == ST_ESCROW) begin
                            n_job.cmd = CMD_STACK;
                        end else begin
                            n_job.cmd = CMD_POLL;
                        end
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
            OP_DISABLE: begin
                // enable with every bill type masked off
                has_job    = 1'b1;
                n_job.kind = JOB_ENABLE;
                n_job.cmd  = CMD_ENABLE;
                n_job.mask = 48'd0;
            end
            default: begin
            end
        endcase

        if (accept && has_job) begin
            n_job_valid = 1'b1;
        end else if (i_job_take) begin
            n_job_valid = 1'b0;
        end else begin
            n_job_valid = r_job_valid;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 8'd0;
            r_frame_len <= 8'd0;
            r_crc       <= 16'd0;
            r_status    <= 8'd0;
            r_bill      <= 8'd0;
            r_pending   <= ST_IDLE;
            r_last      <= 8'd0;
            r_tick      <= 16'd0;
            r_job_valid <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            if (accept) begin
                r_count     <= n_count;
                r_frame_len <= n_frame_len;
                r_crc       <= n_crc;
                r_status    <= n_status;
                r_bill      <= n_bill;
                r_pending   <= n_pending;
                r_last      <= n_last;
                r_tick      <= n_tick;
            end
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (accept && has_job) begin
            r_job <= n_job;
        end
    end

endmodule

/* rtl/core/bvph_tx.sv */
// transmitter: turns a job into result transactions with crc appended
module bvph_tx (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bvph_pkg::t_job  i_job,
    input  logic            i_job_valid,
    output logic            o_job_take,
    bvph_out_if.source      o_tx
);
    import bvph_pkg::*;

    t_job        r_job;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic [15:0] r_crc;

    logic        r_out_valid;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_tx_last;
    logic        r_frame_done;
    logic        r_frame_ok;
    logic [7:0]  r_status;
    logic [12:0] r_credit;

    logic [3:0]  len;
    logic [7:0]  cur_byte;
    logic        is_data;
    logic        is_last;
    logic        advance;
    logic        emit;

    // byte at the current frame position
    always_comb begin
        unique case (r_job.kind)
            JOB_REPORT: len = 4'd1;
            JOB_SHORT:  len = LEN_SHORT[3:0];
            JOB_ENABLE: len = LEN_ENABLE[3:0];
            default:    len = 4'd1;
        endcase
        is_last  = (r_idx == len - 4'd1);
        is_data  = (r_job.kind != JOB_REPORT) && (r_idx < len - 4'd2);
        cur_byte = 8'h00;
        if (r_job.kind == JOB_REPORT) begin
            cur_byte = 8'h00;
        end else if (r_idx == len - 4'd1) begin
            cur_byte = r_crc[15:8];
        end else if (r_idx == len - 4'd2) begin
            cur_byte = r_crc[7:0];
        end else begin
            case (r_idx)
                4'd0:    cur_byte = SYNC_BYTE;
                4'd1:    cur_byte = r_job.addr;
                4'd2:    cur_byte = (r_job.kind == JOB_ENABLE) ? LEN_ENABLE : LEN_SHORT;
                4'd3:    cur_byte = r_job.cmd;
                4'd4:    cur_byte = r_job.mask[47:40];
                4'd5:    cur_byte = r_job.mask[39:32];
                4'd6:    cur_byte = r_job.mask[31:24];
                4'd7:    cur_byte = r_job.mask[23:16];
                4'd8:    cur_byte = r_job.mask[15:8];
                4'd9:    cur_byte = r_job.mask[7:0];
                default: cur_byte = 8'h00;
            endcase
        end
    end

    assign advance    = !r_out_valid || o_tx.ready;
    assign emit       = r_busy && advance;
    assign o_job_take = i_job_valid && (!r_busy || (emit && is_last));

    // sequencing through the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_job_take) begin
            r_busy <= 1'b1;
        end else if (emit && is_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
            r_idx <= 4'd0;
            r_crc <= 16'd0;
        end else if (emit) begin
            r_idx <= r_idx + 4'd1;
            if (is_data) begin
                r_crc <= crc_step(r_crc, cur_byte);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_tx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_tx_valid   <= (r_job.kind != JOB_REPORT);
            r_tx_byte    <= cur_byte;
            r_tx_last    <= is_last;
            r_frame_done <= (r_idx == 4'd0) && r_job.frame_done;
            r_frame_ok   <= (r_idx == 4'd0) && r_job.frame_ok;
            r_status     <= r_job.status;
            r_credit     <= (r_idx == 4'd0) ? r_job.credit : 13'd0;
        end
    end

    assign o_tx.valid         = r_out_valid;
    assign o_tx.tx_valid      = r_tx_valid;
    assign o_tx.tx_byte       = r_tx_byte;
    assign o_tx.tx_last       = r_tx_last;
    assign o_tx.frame_done    = r_frame_done;
    assign o_tx.frame_ok      = r_frame_ok;
    assign o_tx.device_status = r_status;
    assign o_tx.credit        = r_credit;

endmodule

/* rtl/core/bill_validator_poll_host.sv */
// Host controller for a bill-validator serial link. Each event transaction (received byte,
// millisecond tick, disable request) is handled in the cycle it is accepted; a new event can
// be taken every cycle while the one-entry job register is free or being drained. An event
// that produces output yields one result transaction per outgoing byte (6 for ACK and short
// commands, 12 for ENABLE, crc included) or a single report transaction with tx_valid low;
// the transmitter emits one result per cycle while o_tx is ready, so the sustained rate is set
// by the result count. Quiet events give no results. Configuration writes take effect
// at once and belong to idle periods.
module bill_validator_poll_host (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bvph_in_if.sink      i_ev,
    bvph_out_if.source   o_tx,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [47:0]  i_cfg_wdata
);
    import bvph_pkg::*;

    logic [15:0] r_poll_interval;
    logic [7:0]  r_device_addr;
    logic [47:0] r_enable_mask;

    t_job        job;
    logic        job_valid;
    logic        job_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_interval <= POLL_INTERVAL_RST;
            r_device_addr   <= DEVICE_ADDR_RST;
            r_enable_mask   <= ENABLE_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLL_INTERVAL: r_poll_interval <= i_cfg_wdata[15:0];
                CFG_DEVICE_ADDR:   r_device_addr   <= i_cfg_wdata[7:0];
                CFG_ENABLE_MASK:   r_enable_mask   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // event handling
    bvph_event u_event (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ev            (i_ev),
        .i_poll_interval (r_poll_interval),
        .i_device_addr   (r_device_addr),
        .i_enable_mask   (r_enable_mask),
        .o_job           (job),
        .o_job_valid     (job_valid),
        .i_job_take      (job_take)
    );

    // frame transmitter
    bvph_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_take  (job_take),
        .o_tx        (o_tx)
    );

endmodule
